// ===== hw/rtl/rrfc_pkg.sv =====
package rrfc_pkg;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [7:0]  FuncCode  = 8'h04;
  localparam logic [8:0]  FrameBase = 9'd5;
  localparam logic [6:0]  MaxRegs   = 7'd125;
  localparam logic [7:0]  CountMax  = 8'd255;

  localparam logic [7:0]  SlaveReset = 8'd1;
  localparam logic [6:0]  RegsReset  = 7'd1;

  localparam logic CfgExpectedSlave     = 1'b0;
  localparam logic CfgExpectedRegisters = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic [15:0] crc_running;
    logic [7:0]  bytes_seen;
    logic        header_good;
  } frame_state_t;

endpackage

// ===== hw/rtl/rrfc_if.sv =====
interface rrfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface rrfc_result_if;
  logic valid;
  logic ready;
  logic frame_ok;

  modport source (output valid, output frame_ok, input ready);
  modport sink (input valid, input frame_ok, output ready);
endinterface

// ===== hw/rtl/rrfc_in_stage.sv =====
module rrfc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrfc_byte_if.sink     in_i,
  input  logic          advance_i,
  output logic          valid_o,
  output rrfc_pkg::beat_t beat_o
);
  import rrfc_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign in_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      beat_q.frame_byte <= in_i.frame_byte;
      beat_q.last_byte  <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

// ===== hw/rtl/rrfc_crc_byte.sv =====
module rrfc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);
  import rrfc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end
endmodule

// ===== hw/rtl/rrfc_frame_check.sv =====
module rrfc_frame_check (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  rrfc_pkg::beat_t        beat_i,
  input  logic [7:0]             exp_slave_i,
  input  logic [6:0]             exp_regs_i,
  output logic                   frame_ok_o,
  output rrfc_pkg::frame_state_t state_o
);
  import rrfc_pkg::*;

  frame_state_t state_q, state_d;
  logic [15:0]  crc_next;
  logic [7:0]   count_next;
  logic         header_next;
  logic [8:0]   want_len;

  rrfc_crc_byte u_crc (
    .crc_i  (state_q.crc_running),
    .data_i (beat_i.frame_byte),
    .crc_o  (crc_next)
  );

  always_comb begin
    header_next = state_q.header_good;
    if (state_q.bytes_seen == 8'd0 && beat_i.frame_byte != exp_slave_i) begin
      header_next = 1'b0;
    end
    if (state_q.bytes_seen == 8'd1 && beat_i.frame_byte != FuncCode) begin
      header_next = 1'b0;
    end
    if (state_q.bytes_seen == 8'd2 && beat_i.frame_byte != {exp_regs_i, 1'b0}) begin
      header_next = 1'b0;
    end

    count_next = (state_q.bytes_seen == CountMax) ? CountMax : state_q.bytes_seen + 8'd1;
    want_len   = FrameBase + {1'b0, exp_regs_i, 1'b0};

    frame_ok_o = header_next && (crc_next == 16'h0000) && (exp_regs_i <= MaxRegs)
                 && ({1'b0, count_next} == want_len);

    state_d = state_q;
    if (advance_i) begin
      if (beat_i.last_byte) begin
        state_d.crc_running = CrcInit;
        state_d.bytes_seen  = 8'd0;
        state_d.header_good = 1'b1;
      end else begin
        state_d.crc_running = crc_next;
        state_d.bytes_seen  = count_next;
        state_d.header_good = header_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.crc_running <= CrcInit;
      state_q.bytes_seen  <= 8'd0;
      state_q.header_good <= 1'b1;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;
endmodule

// ===== hw/rtl/read_response_frame_checker_core.sv =====
// Channel    Dir  Payload                  Beat
// in_i       in   frame_byte[8], last_byte one byte of a response frame
// out_o      out  frame_ok[1]              one result per frame, on the last byte
// cfg_*      in   cfg_idx_i, cfg_data_i[8] register write, taken when cfg_we_i is high
//
// One byte is accepted every cycle unless a last byte is held in the input
// register by a stalled result. The CRC byte update and header checks run on
// the beat in the input register, then a result moves to the output register.
// Reset clears the frame state to an empty frame and restores the registers.
// A stalled result holds only the last byte in the input register; other bytes
// keep flowing.
module read_response_frame_checker_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  rrfc_byte_if.sink     in_i,
  rrfc_result_if.source out_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [7:0]    cfg_data_i
);
  import rrfc_pkg::*;

  logic [7:0]   exp_slave_q;
  logic [6:0]   exp_regs_q;
  logic         stage_valid;
  beat_t        stage_beat;
  logic         advance;
  logic         out_free;
  logic         frame_ok;
  frame_state_t state;
  logic         out_valid_q, out_valid_d;
  logic         out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_slave_q <= SlaveReset;
      exp_regs_q  <= RegsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgExpectedSlave:     exp_slave_q <= cfg_data_i;
        CfgExpectedRegisters: exp_regs_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign advance  = stage_valid && (!stage_beat.last_byte || out_free);

  rrfc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .beat_o    (stage_beat)
  );

  rrfc_frame_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .beat_i      (stage_beat),
    .exp_slave_i (exp_slave_q),
    .exp_regs_i  (exp_regs_q),
    .frame_ok_o  (frame_ok),
    .state_o     (state)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && stage_beat.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_beat.last_byte) begin
      out_ok_q <= frame_ok;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.frame_ok = out_ok_q;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && stage_beat.last_byte))
    else $error("result appeared without a last byte");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_beat.last_byte) |=>
      (state.bytes_seen == 8'd0 && state.crc_running == CrcInit && state.header_good))
    else $error("frame state not cleared after result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !(advance && stage_beat.last_byte))
    else $error("pending result overwritten");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid |-> in_i.ready)
    else $error("input stalled with empty stage");
endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_data;

  rrfc_byte_if   in_if ();
  rrfc_result_if out_if ();

  read_response_frame_checker_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  logic [7:0]  cfg_slave = SlaveReset;
  logic [6:0]  cfg_regs  = RegsReset;

  logic [15:0] crc_acc     = CrcInit;
  logic [7:0]  frame_count = '0;
  logic        header_ok   = 1'b1;

  logic [7:0]  frame_buf[$];
  beat_t       pending_beats[$];
  logic        expected_verdicts[$];
  beat_t       next_beat;

  int  beats_queued   = 0;
  int  beats_accepted = 0;
  int  item_total     = 0;
  int  cycle_count    = 0;
  int  mismatch_count = 0;
  bit  beat_taken     = 1'b0;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit take_gap();
    if (cycle_count >= 1500 && cycle_count < 3000) return 1'b0;
    return $urandom_range(0, 99) < 16;
  endfunction

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [8:0] want_len;
    logic       verdict;
    if (frame_count == 8'd0 && b != cfg_slave) header_ok = 1'b0;
    if (frame_count == 8'd1 && b != FuncCode) header_ok = 1'b0;
    if (frame_count == 8'd2 && b != {cfg_regs, 1'b0}) header_ok = 1'b0;
    crc_acc = crc16_byte(crc_acc, b);
    if (frame_count != CountMax) frame_count++;
    if (last) begin
      want_len = FrameBase + {1'b0, cfg_regs, 1'b0};
      verdict = (cfg_regs <= MaxRegs) && ({1'b0, frame_count} == want_len) && header_ok &&
                (crc_acc == 16'h0000);
      expected_verdicts.push_back(verdict);
      crc_acc     = CrcInit;
      frame_count = '0;
      header_ok   = 1'b1;
    end
  endtask

  task automatic append_crc();
    logic [15:0] c;
    c = CrcInit;
    foreach (frame_buf[i]) c = crc16_byte(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endtask

  task automatic make_frame(input logic [7:0] slave, input logic [7:0] func,
                            input logic [6:0] regs, input int extra);
    int n;
    frame_buf = {};
    frame_buf.push_back(slave);
    frame_buf.push_back(func);
    frame_buf.push_back({regs, 1'b0});
    n = 2 * int'(regs) + extra;
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    append_crc();
  endtask

  task automatic send_frame();
    beat_t b;
    foreach (frame_buf[i]) begin
      b.frame_byte = frame_buf[i];
      b.last_byte  = (i == frame_buf.size() - 1);
      pending_beats.push_back(b);
    end
    beats_queued += frame_buf.size();
    item_total   += frame_buf.size();
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (beats_accepted != beats_queued || expected_verdicts.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] slave, input logic [6:0] regs);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgExpectedSlave;
    cfg_data <= slave;
    @(negedge clk);
    cfg_idx  <= CfgExpectedRegisters;
    cfg_data <= {1'b0, regs};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_slave = slave;
    cfg_regs  = regs;
    @(posedge clk);
  endtask

  task automatic random_frame();
    int kind;
    int idx;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      make_frame(cfg_slave, FuncCode, cfg_regs, 0);
    end else if (kind < 68) begin
      make_frame(cfg_slave, FuncCode, cfg_regs, 0);
      idx = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
    end else if (kind < 75) begin
      make_frame(cfg_slave, FuncCode, cfg_regs, 0);
      idx = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > idx) void'(frame_buf.pop_back());
    end else if (kind < 80) begin
      if (cfg_regs != 0 && $urandom_range(0, 1) == 0) begin
        make_frame(cfg_slave, FuncCode, cfg_regs, -1);
      end else begin
        make_frame(cfg_slave, FuncCode, cfg_regs, $urandom_range(1, 3));
      end
    end else if (kind < 85) begin
      make_frame(8'($urandom_range(0, 255)), FuncCode, cfg_regs, 0);
    end else if (kind < 88) begin
      make_frame(cfg_slave, 8'($urandom_range(0, 255)), cfg_regs, 0);
    end else if (kind < 92) begin
      make_frame(cfg_slave, FuncCode, 7'($urandom_range(0, 6)), 0);
    end else begin
      frame_buf = {};
      idx = $urandom_range(1, 10);
      for (int i = 0; i < idx; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_frame();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count++;
      beat_taken = in_if.valid && in_if.ready;
      if (beat_taken) begin
        beats_accepted++;
        track_frame_byte(in_if.frame_byte, in_if.last_byte);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual frame_ok=%0b",
                   $time, out_if.frame_ok);
          mismatch_count++;
        end else if (expected_verdicts[0] !== out_if.frame_ok) begin
          $display("%0t: frame_ok mismatch, expected %0b, actual %0b",
                   $time, expected_verdicts[0], out_if.frame_ok);
          mismatch_count++;
          void'(expected_verdicts.pop_front());
        end else begin
          void'(expected_verdicts.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.frame_byte <= '0;
      in_if.last_byte  <= 1'b0;
      out_if.ready     <= 1'b0;
    end else begin
      out_if.ready <= !take_gap();
      if (!in_if.valid || beat_taken) begin
        if (pending_beats.size() != 0 && !take_gap()) begin
          next_beat = pending_beats.pop_front();
          in_if.valid      <= 1'b1;
          in_if.frame_byte <= next_beat.frame_byte;
          in_if.last_byte  <= next_beat.last_byte;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    int          phase_start;
    logic [7:0]  slave;
    logic [6:0]  regs;
    int          pick;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CfgExpectedSlave;
    cfg_data         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    make_frame(SlaveReset, FuncCode, RegsReset, 0);
    send_frame();
    make_frame(8'd2, FuncCode, RegsReset, 0);
    send_frame();
    make_frame(SlaveReset, 8'h03, RegsReset, 0);
    send_frame();
    make_frame(SlaveReset, FuncCode, 7'd2, 0);
    send_frame();
    frame_buf = {SlaveReset};
    send_frame();
    make_frame(SlaveReset, FuncCode, RegsReset, 0);
    frame_buf[frame_buf.size() - 1] ^= 8'h80;
    send_frame();

    wait_idle();
    set_config(8'h00, 7'd0);
    make_frame(8'h00, FuncCode, 7'd0, 0);
    send_frame();
    frame_buf = {8'h00, FuncCode, 8'h00};
    send_frame();

    wait_idle();
    set_config(8'hFF, MaxRegs);
    make_frame(8'hFF, FuncCode, MaxRegs, 0);
    send_frame();
    make_frame(8'hFF, FuncCode, MaxRegs, 3);
    send_frame();
    make_frame(8'hFF, FuncCode, MaxRegs, -1);
    send_frame();

    wait_idle();
    set_config(8'hA5, 7'd126);
    make_frame(8'hA5, FuncCode, 7'd126, 0);
    send_frame();

    wait_idle();
    set_config(8'h5A, 7'd127);
    make_frame(8'h5A, FuncCode, 7'd127, -240);
    send_frame();

    while (item_total < 1550) begin
      wait_idle();
      pick = $urandom_range(0, 99);
      slave = (pick < 10) ? 8'h00 : (pick < 20) ? 8'hFF : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 80) regs = 7'($urandom_range(0, 6));
      else if (pick < 90) regs = 7'($urandom_range(7, 20));
      else if (pick < 95) regs = MaxRegs;
      else regs = 7'($urandom_range(126, 127));
      set_config(slave, regs);
      phase_start = item_total;
      while (item_total - phase_start < 150) random_frame();
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
